[sv/gfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfc_pkg: shared types and constants of the gated frequency counter
// Holds item layouts, action and register codes, mode codes and the small
// mode decode functions used by the front end and the back end.
// ----------------------------------------------------------------------------
package gfc_pkg;

  localparam int ACT_W       = 3;
  localparam int TIME_W      = 32;
  localparam int VALUE_W     = 32;
  localparam int DEC_W       = 3;
  localparam int MODE_W      = 4;
  localparam int TICKS_W     = 16;
  localparam int GATE_W      = 16;
  localparam int LEFT_W      = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_W       = 44;

  // Action codes of an input item.
  localparam logic [ACT_W-1:0] ACT_TICK      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_EDGE      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GATE_FALL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GATE_RISE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 1'b1;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_OFF        = 4'd0;
  localparam logic [MODE_W-1:0] MODE_GATE_100   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_GATE_1     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_GATE_10    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_GATE_1000  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_GATE_10000 = 4'd5;
  localparam logic [MODE_W-1:0] MODE_EXT_GATE   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_PERIOD_1   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_PERIOD_10  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_PERIOD_100 = 4'd9;

  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd500;
  localparam logic [VALUE_W-1:0] TOO_FAST      = 32'd999999;
  localparam logic [DEC_W-1:0]   PERIOD_DEC    = 3'd5;

  // Scale numerators: 10^11 times the number of averaged edges.
  localparam logic [DIV_W-1:0] SCALE_1   = 44'd100000000000;
  localparam logic [DIV_W-1:0] SCALE_10  = 44'd1000000000000;
  localparam logic [DIV_W-1:0] SCALE_100 = 44'd10000000000000;

  // At or below this period (24 us per averaged edge) the signal is too fast.
  localparam logic [VALUE_W-1:0] LIMIT_1   = 32'd24;
  localparam logic [VALUE_W-1:0] LIMIT_10  = 32'd240;
  localparam logic [VALUE_W-1:0] LIMIT_100 = 32'd2400;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] freq_value;
    logic [DEC_W-1:0]   decimals;
    logic [VALUE_W-1:0] raw_count;
    logic               was_fresh;
  } out_item_t;

  // Classified operation passed from the front end to the back end.
  typedef struct packed {
    logic              tick;
    logic              sig_edge;
    logic              gate_fall;
    logic              gate_rise;
    logic              read;
    logic [TIME_W-1:0] time_us;
  } op_t;

  function automatic logic is_period(input logic [MODE_W-1:0] m);
    return (m == MODE_PERIOD_1) || (m == MODE_PERIOD_10) || (m == MODE_PERIOD_100);
  endfunction

  function automatic logic [LEFT_W-1:0] avg_edges(input logic [MODE_W-1:0] m);
    logic [LEFT_W-1:0] a;
    case (m)
      MODE_PERIOD_10:  a = 7'd10;
      MODE_PERIOD_100: a = 7'd100;
      default:         a = 7'd1;
    endcase
    return a;
  endfunction

  function automatic logic [GATE_W-1:0] gate_len(input logic [MODE_W-1:0]  m,
                                                 input logic [TICKS_W-1:0] t);
    logic [GATE_W-1:0] g;
    case (m)
      MODE_GATE_100:   g = 16'd100;
      MODE_GATE_1:     g = 16'd1;
      MODE_GATE_10:    g = 16'd10;
      MODE_GATE_1000:  g = 16'd1000;
      MODE_GATE_10000: g = 16'd10000;
      MODE_EXT_GATE:   g = 16'd100;
      MODE_PERIOD_1,
      MODE_PERIOD_10,
      MODE_PERIOD_100: g = t;
      default:         g = 16'd0;
    endcase
    return g;
  endfunction

  function automatic logic [DIV_W-1:0] period_scale(input logic [MODE_W-1:0] m);
    logic [DIV_W-1:0] s;
    case (m)
      MODE_PERIOD_10:  s = SCALE_10;
      MODE_PERIOD_100: s = SCALE_100;
      default:         s = SCALE_1;
    endcase
    return s;
  endfunction

  function automatic logic [VALUE_W-1:0] period_limit(input logic [MODE_W-1:0] m);
    logic [VALUE_W-1:0] l;
    case (m)
      MODE_PERIOD_10:  l = LIMIT_10;
      MODE_PERIOD_100: l = LIMIT_100;
      default:         l = LIMIT_1;
    endcase
    return l;
  endfunction

endpackage

[sv/gfc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfc_front: input acceptance and action decode
// Takes input items, drops unused action codes, and holds one classified
// operation until the queue has room for it.
// ----------------------------------------------------------------------------
module gfc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  gfc_pkg::in_item_t in_item,
  output logic             push,
  output gfc_pkg::op_t     push_op,
  input  logic             q_full
);
  import gfc_pkg::*;

  logic front_valid;
  op_t  front_op;
  op_t  dec_op;
  logic accept;

  // Decode the action code into one bit per operation.
  always_comb begin
    dec_op           = '0;
    dec_op.time_us   = in_item.time_us;
    dec_op.tick      = (in_item.action == ACT_TICK);
    dec_op.sig_edge  = (in_item.action == ACT_EDGE);
    dec_op.gate_fall = (in_item.action == ACT_GATE_FALL);
    dec_op.gate_rise = (in_item.action == ACT_GATE_RISE);
    dec_op.read      = (in_item.action == ACT_READ);
  end

  assign in_stall = front_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = front_valid && !q_full;
  assign push_op  = front_op;

  // Holding register; items with no operation are accepted and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= dec_op.tick || dec_op.sig_edge || dec_op.gate_fall ||
                     dec_op.gate_rise || dec_op.read;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_op <= dec_op;
    end
  end

endmodule

[sv/gfc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfc_queue: operation queue between front end and back end
// A small first-in first-out buffer in registers.
// ----------------------------------------------------------------------------
module gfc_queue #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  gfc_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output gfc_pkg::op_t head_op
);
  import gfc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  op_t              store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_op   = store[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_op;
    end
  end

endmodule

[sv/gfc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfc_back: measurement state, read scaling and period divider
// Runs one queued operation per cycle unless dividing or a read awaits output.
// Period reads needing a quotient use a restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module gfc_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gfc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_not_empty,
  input  gfc_pkg::op_t                        head_op,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gfc_pkg::out_item_t                  out_item
);
  import gfc_pkg::*;

  localparam int DCNT_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } back_state_t;

  // Configuration and measurement state.
  logic [MODE_W-1:0]      mode;
  logic [TICKS_W-1:0]     timeout_ticks;
  logic [GATE_W-1:0]      gate_countdown, gate_countdown_next;
  logic [COUNT_WIDTH-1:0] edge_count, edge_count_next;
  logic                   counting_on, counting_on_next;
  logic [VALUE_W-1:0]     measured, measured_next;
  logic                   fresh, fresh_next;
  logic [LEFT_W-1:0]      edges_left, edges_left_next;
  logic [TIME_W-1:0]      start_stamp, start_stamp_next;
  logic                   start_valid, start_valid_next;

  back_state_t        state;
  logic [DIV_W-1:0]   div_dvd;
  logic [VALUE_W-1:0] div_rem;
  logic [VALUE_W-1:0] div_dvs;
  logic [DCNT_W-1:0]  div_cnt;
  logic [VALUE_W:0]   div_shift;
  logic               div_ge;
  logic [VALUE_W-1:0] res_raw;
  logic               res_fresh;

  logic               per;
  logic [LEFT_W-1:0]  avg;
  logic [GATE_W-1:0]  glen;
  logic [GATE_W-1:0]  gc_dec;
  logic               need_div;
  logic               out_free;
  logic               read_direct;
  logic               div_finish;
  logic [MODE_W-1:0]  cfg_mode;
  out_item_t          read_item;

  assign per      = is_period(mode);
  assign avg      = avg_edges(mode);
  assign glen     = gate_len(mode, timeout_ticks);
  assign gc_dec   = gate_countdown - 1'b1;
  assign need_div = per && fresh && (measured > period_limit(mode));
  assign out_free = !out_valid || !out_stall;
  assign cfg_mode = cfg_data[MODE_W-1:0];

  // Take the head operation; a direct read also needs a free output register.
  assign pop = (state == ST_RUN) && q_not_empty &&
               (!head_op.read || need_div || out_free);
  assign read_direct = pop && head_op.read && !need_div;
  assign div_finish  = (state == ST_DIV) && (div_cnt == '0) && out_free;

  // Result of a read that needs no division.
  always_comb begin
    read_item           = '0;
    read_item.raw_count = measured;
    read_item.was_fresh = fresh;
    if (per) begin
      if (measured == 32'd1) begin
        read_item.freq_value = '0;
        read_item.decimals   = PERIOD_DEC;
      end else begin
        read_item.freq_value = TOO_FAST;
        read_item.decimals   = '0;
      end
    end else begin
      case (mode)
        MODE_OFF, MODE_GATE_1: begin
          read_item.freq_value = (measured << 6) + (measured << 5) + (measured << 2);
          read_item.decimals   = 3'd0;
        end
        MODE_GATE_10: begin
          read_item.freq_value = (measured << 3) + (measured << 1);
          read_item.decimals   = 3'd0;
        end
        MODE_GATE_1000: begin
          read_item.freq_value = measured;
          read_item.decimals   = 3'd1;
        end
        MODE_GATE_10000: begin
          read_item.freq_value = measured;
          read_item.decimals   = 3'd2;
        end
        default: begin
          read_item.freq_value = measured;
          read_item.decimals   = 3'd0;
        end
      endcase
    end
  end

  // Next measurement state for the operation taken this cycle.
  always_comb begin
    gate_countdown_next = gate_countdown;
    edge_count_next     = edge_count;
    counting_on_next    = counting_on;
    measured_next       = measured;
    fresh_next          = fresh;
    edges_left_next     = edges_left;
    start_stamp_next    = start_stamp;
    start_valid_next    = start_valid;
    if (pop) begin
      if (head_op.tick) begin
        if (gate_countdown != '0) begin
          gate_countdown_next = gc_dec;
          if (gc_dec == '0) begin
            if (per) begin
              if (!fresh) begin
                edges_left_next  = avg;
                start_valid_next = 1'b0;
                measured_next    = 32'd1;
                fresh_next       = 1'b1;
              end
            end else begin
              measured_next    = VALUE_W'(edge_count);
              fresh_next       = fresh || counting_on;
              edge_count_next  = '0;
              counting_on_next = 1'b1;
            end
            gate_countdown_next = glen;
          end
        end
      end else if (head_op.sig_edge) begin
        if (per) begin
          if (edges_left > 7'd1) begin
            edges_left_next = edges_left - 1'b1;
          end else begin
            edges_left_next = avg;
            if (start_valid) begin
              measured_next = head_op.time_us - start_stamp;
              fresh_next    = 1'b1;
            end
            gate_countdown_next = glen;
            start_stamp_next    = head_op.time_us;
            start_valid_next    = 1'b1;
          end
        end else if (counting_on) begin
          edge_count_next = edge_count + 1'b1;
        end
      end else if (head_op.gate_fall) begin
        if (mode == MODE_EXT_GATE) begin
          edge_count_next  = '0;
          counting_on_next = 1'b1;
        end
      end else if (head_op.gate_rise) begin
        if (mode == MODE_EXT_GATE) begin
          measured_next    = VALUE_W'(edge_count);
          edge_count_next  = '0;
          fresh_next       = fresh || counting_on;
          counting_on_next = 1'b0;
        end
      end else if (head_op.read) begin
        fresh_next = 1'b0;
      end
    end
  end

  // Configuration registers and measurement state; an in-range mode write restarts.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_OFF;
      timeout_ticks  <= TIMEOUT_RESET;
      gate_countdown <= '0;
      edge_count     <= '0;
      counting_on    <= 1'b0;
      measured       <= '0;
      fresh          <= 1'b0;
      edges_left     <= '0;
      start_stamp    <= '0;
      start_valid    <= 1'b0;
    end else if (cfg_we && (cfg_index == REG_MODE)) begin
      if (cfg_mode <= MODE_PERIOD_100) begin
        mode           <= cfg_mode;
        gate_countdown <= ((cfg_mode != MODE_OFF) && (cfg_mode != MODE_EXT_GATE)) ?
                          16'd1 : 16'd0;
        edge_count     <= '0;
        counting_on    <= 1'b0;
        measured       <= '0;
        fresh          <= 1'b0;
        edges_left     <= is_period(cfg_mode) ? avg_edges(cfg_mode) : '0;
        start_stamp    <= '0;
        start_valid    <= 1'b0;
      end
    end else if (cfg_we && (cfg_index == REG_TIMEOUT)) begin
      timeout_ticks <= cfg_data[TICKS_W-1:0];
    end else begin
      gate_countdown <= gate_countdown_next;
      edge_count     <= edge_count_next;
      counting_on    <= counting_on_next;
      measured       <= measured_next;
      fresh          <= fresh_next;
      edges_left     <= edges_left_next;
      start_stamp    <= start_stamp_next;
      start_valid    <= start_valid_next;
    end
  end

  // One restoring division step.
  assign div_shift = {div_rem, div_dvd[DIV_W-1]};
  assign div_ge    = (div_shift >= {1'b0, div_dvs});

  // Sequencer: run operations, or divide for a period-mode read.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else if (pop && head_op.read && need_div) begin
      state <= ST_DIV;
    end else if (div_finish) begin
      state <= ST_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.read && need_div) begin
      div_dvd   <= period_scale(mode);
      div_rem   <= '0;
      div_dvs   <= measured;
      div_cnt   <= DCNT_W'(DIV_W);
      res_raw   <= measured;
      res_fresh <= fresh;
    end else if ((state == ST_DIV) && (div_cnt != '0)) begin
      div_dvd <= {div_dvd[DIV_W-2:0], div_ge};
      div_rem <= div_ge ? VALUE_W'(div_shift - {1'b0, div_dvs}) : div_shift[VALUE_W-1:0];
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (read_direct || div_finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_direct) begin
      out_item <= read_item;
    end else if (div_finish) begin
      out_item.freq_value <= div_dvd[VALUE_W-1:0];
      out_item.decimals   <= PERIOD_DEC;
      out_item.raw_count  <= res_raw;
      out_item.was_fresh  <= res_fresh;
    end
  end

endmodule

[sv/gated_frequency_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_frequency_counter_core: gated frequency and period counter
// Counts signal edges over internal or external gates, or times groups of
// edges with microsecond stamps, and reports a scaled frequency on read.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | in_item (action, time_us)
//   out     | output    | out_valid/out_stall| out_item (freq, decimals, raw, fresh)
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Ticks, edges, gate edges and most reads are handled directly in the back end.
// A period-mode read with a fresh, valid period runs the 44-bit restoring
// divider, one quotient bit per cycle, before its reading goes to the output.
// Reset is synchronous and clears all control and measurement state.
// The queue of QUEUE_DEPTH items absorbs output stalls and divider time;
// input is stalled only when the queue and the front register are full.
// ----------------------------------------------------------------------------
module gated_frequency_counter_core #(
  parameter int COUNT_WIDTH = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gfc_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gfc_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [gfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gfc_pkg::*;

  logic push;
  op_t  push_op;
  logic q_full;
  logic pop;
  logic q_not_empty;
  op_t  head_op;

  // Accept and classify items.
  gfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .push_op  (push_op),
    .q_full   (q_full)
  );

  // Decoupling queue.
  gfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  // Measurement, scaling and output.
  gfc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .head_op     (head_op),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

[test/gfc_reading_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfc_reading_checker: reading predictor and comparator for the counter core
// Watches the input, output and register write ports of the gated frequency
// counter, keeps its own copy of the measurement state, works out the reading
// that every accepted read item must return and compares each returned item
// field by field, oldest first. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module gfc_reading_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  gfc_pkg::in_item_t               in_item,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  gfc_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [gfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gfc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending
);

  import gfc_pkg::*;

  localparam logic [63:0] PERIOD_NUMERATOR = 64'd100000000000;
  localparam logic [31:0] MIN_US_PER_EDGE  = 32'd24;

  // Register copies.
  logic [MODE_W-1:0]  cur_mode;
  logic [TICKS_W-1:0] timeout_reg;

  // Measurement state.
  logic [GATE_W-1:0]  gate_left;
  logic [31:0]        edge_tally;
  logic               counting;
  logic [31:0]        held_value;
  logic               fresh_flag;
  logic [LEFT_W-1:0]  edges_to_go;
  logic [31:0]        stamp_start;
  logic               stamp_ok;

  out_item_t expected_readings[$];

  function automatic logic in_period_mode(input logic [MODE_W-1:0] m);
    return (m >= MODE_PERIOD_1) && (m <= MODE_PERIOD_100);
  endfunction

  // Number of edges that make up one timed period.
  function automatic logic [LEFT_W-1:0] edges_per_period(input logic [MODE_W-1:0] m);
    if (m == MODE_PERIOD_100) return 7'd100;
    if (m == MODE_PERIOD_10) return 7'd10;
    return 7'd1;
  endfunction

  // Countdown reload in ticks for the current mode.
  function automatic logic [GATE_W-1:0] reload_ticks(input logic [MODE_W-1:0]  m,
                                                     input logic [TICKS_W-1:0] t);
    logic [GATE_W-1:0] r;
    r = '0;
    if (in_period_mode(m)) begin
      r = t;
    end else begin
      case (m)
        MODE_GATE_1:                  r = 16'd1;
        MODE_GATE_10:                 r = 16'd10;
        MODE_GATE_100, MODE_EXT_GATE: r = 16'd100;
        MODE_GATE_1000:               r = 16'd1000;
        MODE_GATE_10000:              r = 16'd10000;
        default:                      r = '0;
      endcase
    end
    return r;
  endfunction

  // A mode write clears everything; timed modes start with a one-tick countdown.
  task automatic restart_counter();
    gate_left   = ((cur_mode != MODE_OFF) && (cur_mode != MODE_EXT_GATE)) ? 16'd1 : 16'd0;
    edge_tally  = '0;
    counting    = 1'b0;
    held_value  = '0;
    fresh_flag  = 1'b0;
    edges_to_go = in_period_mode(cur_mode) ? edges_per_period(cur_mode) : '0;
    stamp_start = '0;
    stamp_ok    = 1'b0;
  endtask

  task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
    if (idx == REG_MODE) begin
      // Mode codes above the last period mode are dropped without a restart.
      if (data[MODE_W-1:0] <= MODE_PERIOD_100) begin
        cur_mode = data[MODE_W-1:0];
        restart_counter();
      end
    end else begin
      timeout_reg = data[TICKS_W-1:0];
    end
  endtask

  // End of a gate, or a timeout in the period modes.
  task automatic take_tick();
    if (gate_left != 0) begin
      gate_left = gate_left - 1'b1;
      if (gate_left == 0) begin
        if (in_period_mode(cur_mode)) begin
          if (!fresh_flag) begin
            edges_to_go = edges_per_period(cur_mode);
            stamp_ok    = 1'b0;
            held_value  = 32'd1;
            fresh_flag  = 1'b1;
          end
        end else begin
          held_value = edge_tally;
          if (counting) fresh_flag = 1'b1;
          edge_tally = '0;
          counting   = 1'b1;
        end
        gate_left = reload_ticks(cur_mode, timeout_reg);
      end
    end
  endtask

  task automatic take_edge(input logic [31:0] stamp);
    if (in_period_mode(cur_mode)) begin
      if (edges_to_go > 1) begin
        edges_to_go = edges_to_go - 1'b1;
      end else begin
        edges_to_go = edges_per_period(cur_mode);
        if (stamp_ok) begin
          held_value = stamp - stamp_start;
          fresh_flag = 1'b1;
        end
        gate_left   = reload_ticks(cur_mode, timeout_reg);
        stamp_start = stamp;
        stamp_ok    = 1'b1;
      end
    end else if (counting) begin
      edge_tally = edge_tally + 1'b1;
    end
  endtask

  // Scale the stored value into the reading and clear the fresh flag.
  task automatic issue_reading();
    out_item_t   r;
    logic [63:0] wide;
    logic [31:0] floor_us;
    r.raw_count = held_value;
    r.was_fresh = fresh_flag;
    wide        = {32'd0, held_value};
    r.decimals  = '0;
    if (in_period_mode(cur_mode)) begin
      floor_us = MIN_US_PER_EDGE * {25'd0, edges_per_period(cur_mode)};
      if (fresh_flag && (held_value > floor_us)) begin
        wide       = (PERIOD_NUMERATOR * {57'd0, edges_per_period(cur_mode)}) / wide;
        r.decimals = PERIOD_DEC;
      end else if (held_value == 32'd1) begin
        wide       = '0;
        r.decimals = PERIOD_DEC;
      end else begin
        wide = {32'd0, TOO_FAST};
      end
    end else begin
      case (cur_mode)
        MODE_GATE_1, MODE_OFF: wide = wide * 64'd100;
        MODE_GATE_10:          wide = wide * 64'd10;
        MODE_GATE_1000:        r.decimals = 3'd1;
        MODE_GATE_10000:       r.decimals = 3'd2;
        default:               r.decimals = '0;
      endcase
    end
    r.freq_value = wide[31:0];
    fresh_flag   = 1'b0;
    expected_readings.push_back(r);
  endtask

  task automatic counter_step(input in_item_t it);
    case (it.action)
      ACT_TICK: take_tick();
      ACT_EDGE: take_edge(it.time_us);
      ACT_GATE_FALL: begin
        if (cur_mode == MODE_EXT_GATE) begin
          edge_tally = '0;
          counting   = 1'b1;
        end
      end
      ACT_GATE_RISE: begin
        if (cur_mode == MODE_EXT_GATE) begin
          held_value = edge_tally;
          edge_tally = '0;
          if (counting) fresh_flag = 1'b1;
          counting = 1'b0;
        end
      end
      ACT_READ: issue_reading();
      default: ;
    endcase
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      fail_count++;
    end
  endtask

  // Returned items are checked before new items are predicted on the same edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cur_mode    = MODE_OFF;
      timeout_reg = TIMEOUT_RESET;
      restart_counter();
      expected_readings.delete();
      fail_count  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t ns: reading returned with none expected, got %h", $time, out_item);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("freq_value", want.freq_value, out_item.freq_value);
          check_field("decimals", {29'd0, want.decimals}, {29'd0, out_item.decimals});
          check_field("raw_count", want.raw_count, out_item.raw_count);
          check_field("was_fresh", {31'd0, want.was_fresh}, {31'd0, out_item.was_fresh});
        end
      end
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) counter_step(in_item);
    end
    pending = expected_readings.size();
  end

endmodule

[test/tb_gated_frequency_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_frequency_counter_core: testbench of the gated frequency counter
// Drives a short directed sequence through four modes and corners, then random
// phases in every mode with bursty input and a stalling receiver. A separate
// checker predicts each reading; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb_gated_frequency_counter_core;

  import gfc_pkg::*;

  localparam int ITEM_TARGET    = 1050;
  localparam int HOLD_CYCLES    = 300;
  // Divider plus a full queue of items still in flight after the last reading.
  localparam int DRAIN_CYCLES   = 100;
  // Longest quiet stretch of a correct run is the receiver hold-off plus a few
  // divisions queued behind it; this is several times that.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PLANNED    = 10;

  // Action codes that the block ignores.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_item;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;

  int                     items_sent = 0;
  int                     burst_left = 0;
  logic                   gaps_on = 1'b1;
  logic [TIME_W-1:0]      stamp_now = '0;
  int                     hold_asks = 0;
  int                     hold_served = 0;
  int                     quiet_cycles = 0;

  logic [MODE_W-1:0] plan_mode [NUM_PLANNED] = '{MODE_GATE_1, MODE_GATE_10,
      MODE_PERIOD_1, MODE_PERIOD_10, MODE_PERIOD_100, MODE_EXT_GATE, MODE_GATE_100,
      MODE_OFF, MODE_GATE_1000, MODE_GATE_10000};
  int plan_len [NUM_PLANNED] = '{70, 70, 70, 70, 260, 70, 260, 40, 40, 40};
  logic [MODE_W-1:0] extra_modes [5] = '{MODE_GATE_1, MODE_GATE_10, MODE_EXT_GATE,
      MODE_PERIOD_1, MODE_PERIOD_10};

  gated_frequency_counter_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gfc_reading_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stall density changes per stretch; a requested hold-off keeps
  // the output stalled long enough for the block to stall its input.
  initial begin : receiver
    int span;
    int pct;
    out_stall = 1'b0;
    forever begin
      span = $urandom_range(8, 80);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 20;
        2:       pct = 50;
        default: pct = 85;
      endcase
      repeat (span) begin
        @(negedge clk);
        if (hold_served != hold_asks) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_served++;
        end else begin
          out_stall <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  // Offers one item, with a random gap at the start of each burst.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] stamp);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && ($urandom_range(0, 3) != 0)) gap = $urandom_range(1, 8);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_item.action  <= act;
    in_item.time_us <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0]  val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stops offering, waits for every reading, then lets the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] m, input int n);
    int                i;
    int                pick;
    int                run;
    int                speed;
    int                tick_share;
    logic [ACT_W-1:0]  noise_act;
    logic [TIME_W-1:0] delta;
    speed = $urandom_range(0, 3);
    case (m)
      MODE_GATE_100:   tick_share = 80;
      MODE_GATE_1:     tick_share = 30;
      MODE_GATE_10:    tick_share = 45;
      MODE_PERIOD_100: tick_share = 3;
      MODE_PERIOD_1,
      MODE_PERIOD_10:  tick_share = 10;
      default:         tick_share = 40;
    endcase
    i = 0;
    while (i < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // Noise: gate edges out of place, spare codes, stray ticks and edges.
        noise_act = ACT_W'($urandom_range(ACT_TICK, ACT_SPARE_HI));
        if (noise_act == ACT_READ) noise_act = ACT_GATE_FALL;
        send_item(noise_act, $urandom);
      end else if (pick < 11) begin
        send_item(ACT_READ, $urandom);
        i++;
      end else if (m == MODE_EXT_GATE) begin
        // One gate window with a random number of edges inside.
        send_item(ACT_GATE_FALL, $urandom);
        run = $urandom_range(0, 12);
        repeat (run) send_item(ACT_EDGE, $urandom);
        send_item(ACT_GATE_RISE, $urandom);
        i += run + 2;
      end else if ($urandom_range(0, 99) < tick_share) begin
        send_item(ACT_TICK, $urandom);
        i++;
      end else if ((m >= MODE_PERIOD_1) && (m <= MODE_PERIOD_100)) begin
        // Stamps advance at a per-phase speed, from too fast to wide jumps.
        case (speed)
          0:       delta = $urandom_range(0, 30);
          1:       delta = $urandom_range(20, 400);
          2:       delta = $urandom_range(1000, 200000);
          default: delta = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 5000);
        endcase
        stamp_now = stamp_now + delta;
        send_item(ACT_EDGE, stamp_now);
        i++;
      end else begin
        send_item(ACT_EDGE, $urandom);
        i++;
      end
    end
  endtask

  task automatic start_phase(input logic [MODE_W-1:0] m, input int n);
    logic [CFG_DATA_W-1:0] d;
    settle();
    if ((m >= MODE_PERIOD_1) && (m <= MODE_PERIOD_100)) begin
      case ($urandom_range(0, 3))
        0:       d = CFG_DATA_W'($urandom_range(1, 6));
        1:       d = CFG_DATA_W'($urandom_range(20, 300));
        2:       d = 16'hFFFF;
        default: d = CFG_DATA_W'($urandom_range(1, 65535));
      endcase
      write_reg(REG_TIMEOUT, d);
    end else if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom));
    end
    // Occasionally an out-of-range mode, which must leave everything alone.
    if ($urandom_range(0, 4) == 0) begin
      d = CFG_DATA_W'($urandom);
      d[MODE_W-1:0] = MODE_W'($urandom_range(10, 15));
      write_reg(REG_MODE, d);
    end
    d = CFG_DATA_W'($urandom);
    d[MODE_W-1:0] = m;
    write_reg(REG_MODE, d);
    gaps_on   = ($urandom_range(0, 3) != 0);
    stamp_now = $urandom;
    run_phase(m, n);
  endtask

  initial begin : stimulus
    int p;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Off mode after reset: scaled read, ignored edges, ticks and gate edges.
    send_item(ACT_READ, 32'h0000_0000);
    send_item(ACT_EDGE, 32'h0000_0000);
    send_item(ACT_TICK, 32'hFFFF_FFFF);
    send_item(ACT_GATE_FALL, 32'h0000_0000);
    send_item(ACT_SPARE_LO, 32'hFFFF_FFFF);
    send_item(ACT_READ, 32'hFFFF_FFFF);

    // Out-of-range mode is ignored; one-tick gate with a discarded first gate.
    settle();
    write_reg(REG_MODE, 16'h000F);
    write_reg(REG_MODE, {12'h000, MODE_GATE_1});
    send_item(ACT_TICK, 32'h0);
    send_item(ACT_EDGE, 32'h0);
    send_item(ACT_EDGE, 32'h0);
    send_item(ACT_EDGE, 32'h0);
    send_item(ACT_TICK, 32'h0);
    send_item(ACT_READ, 32'h0);
    send_item(ACT_READ, 32'h0);

    // Period mode with a zero timeout: setup timeout, wrapped stamp difference,
    // too-fast period, and a countdown that stays stopped.
    settle();
    write_reg(REG_TIMEOUT, 16'd0);
    write_reg(REG_MODE, {12'h000, MODE_PERIOD_1});
    send_item(ACT_TICK, 32'h0);
    send_item(ACT_READ, 32'h0);
    send_item(ACT_EDGE, 32'hFFFF_FFFF);
    send_item(ACT_EDGE, 32'h0000_001F);
    send_item(ACT_READ, 32'h0);
    send_item(ACT_EDGE, 32'h0000_0023);
    send_item(ACT_READ, 32'h0);
    send_item(ACT_TICK, 32'h0);
    send_item(ACT_READ, 32'h0);

    // External gate window.
    settle();
    write_reg(REG_MODE, {12'hFFF, MODE_EXT_GATE});
    send_item(ACT_GATE_FALL, 32'h0);
    send_item(ACT_EDGE, 32'h0);
    send_item(ACT_EDGE, 32'h0);
    send_item(ACT_GATE_RISE, 32'h0);
    send_item(ACT_READ, 32'h0);

    // Random phases over every mode, then extra phases until the item budget.
    for (p = 0; p < NUM_PLANNED; p++) begin
      if ((p == 0) || (p == 5)) hold_asks++;
      start_phase(plan_mode[p], plan_len[p]);
    end
    while (items_sent < ITEM_TARGET) begin
      start_phase(extra_modes[$urandom_range(0, 4)], $urandom_range(60, 100));
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/gfc_pkg.sv
sv/gfc_front.sv
sv/gfc_queue.sv
sv/gfc_back.sv
sv/gated_frequency_counter_core.sv
test/gfc_reading_checker.sv
test/tb_gated_frequency_counter_core.sv
